// ===== rtl/core/esd_pkg.sv =====
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types, constants and the escape letter table of the escape decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

   localparam int unsigned QueueDepth = 4;

   localparam logic [7:0] Backslash  = 8'h5C;
   localparam logic [7:0] DigitZero  = 8'h30;
   localparam logic [7:0] DigitNine  = 8'h39;
   localparam logic [1:0] MaxDigits  = 2'd3;

   // One classified request: one or two decoded bytes.
   typedef struct packed {
      logic       pair;
      logic [7:0] byte0;
      logic       last0;
      logic [7:0] byte1;
      logic       last1;
   } result_type;

   // Bit 8 set when the letter names a simple escape, bits 7:0 the byte.
   function automatic logic [8:0] simple_escape(input logic [7:0] c);
      logic [8:0] r;
      r = 9'd0;
      case (c)
         "a":     r = {1'b1, 8'h07};
         "b":     r = {1'b1, 8'h08};
         "f":     r = {1'b1, 8'h0C};
         "n":     r = {1'b1, 8'h0A};
         "r":     r = {1'b1, 8'h0D};
         "t":     r = {1'b1, 8'h09};
         "v":     r = {1'b1, 8'h0B};
         8'h27:   r = {1'b1, 8'h27};
         8'h22:   r = {1'b1, 8'h22};
         8'h5C:   r = {1'b1, 8'h5C};
         "?":     r = {1'b1, 8'h3F};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/esd_front.sv =====
// ----------------------------------------------------------------------------
// esd_front
// Accepts characters, runs the escape state and classifies each request into
// zero, one or two decoded bytes for the result queue.
// ----------------------------------------------------------------------------
module esd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_data,
   output logic                 push_valid,
   output esd_pkg::result_type  push_data,
   input  logic                 push_ready
);

   localparam logic [1:0] PH_PLAIN  = 2'd0;
   localparam logic [1:0] PH_ESC    = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;

   logic       skip_ff, skip_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] count_ff, count_in;
   logic [9:0] value_ff, value_in;

   logic       accept;
   logic       is_digit;
   logic [9:0] digit;
   logic [9:0] grown;
   logic [1:0] count_inc;
   logic [8:0] simple;
   logic       has0, has1;
   logic [7:0] b0, b1;
   logic       l0, l1;
   logic       plain_emits;

   assign csr_ready  = 1'b1;
   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;

   assign is_digit    = req_tdata inside {[esd_pkg::DigitZero:esd_pkg::DigitNine]};
   assign digit       = {2'd0, req_tdata - esd_pkg::DigitZero};
   assign grown       = (value_ff << 3) + (value_ff << 1) + digit;
   assign count_inc   = count_ff + 2'd1;
   assign simple      = esd_pkg::simple_escape(req_tdata);
   assign plain_emits = !(req_tdata == esd_pkg::Backslash && !req_tlast);

   always_comb begin
      skip_in  = skip_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      value_in = value_ff;
      has0 = 1'b0;
      has1 = 1'b0;
      b0   = req_tdata;
      l0   = req_tlast;
      b1   = req_tdata;
      l1   = req_tlast;
      if (csr_valid && csr_ready) begin
         skip_in = csr_data;
      end
      case (phase_ff)
         PH_ESC: begin
            if (simple[8]) begin
               phase_in = PH_PLAIN;
               has0 = 1'b1;
               b0   = simple[7:0];
            end else if (!skip_ff && is_digit) begin
               count_in = 2'd1;
               value_in = digit;
               if (req_tlast) begin
                  phase_in = PH_PLAIN;
                  count_in = 2'd0;
                  has0 = 1'b1;
                  b0   = digit[7:0];
               end else begin
                  phase_in = PH_DIGITS;
               end
            end else begin
               has0 = 1'b1;
               b0   = esd_pkg::Backslash;
               l0   = 1'b0;
               has1 = plain_emits;
               phase_in = plain_emits ? PH_PLAIN : PH_ESC;
            end
         end
         PH_DIGITS: begin
            if (is_digit && count_ff < esd_pkg::MaxDigits) begin
               value_in = grown;
               count_in = count_inc;
               if (count_inc >= esd_pkg::MaxDigits || req_tlast) begin
                  phase_in = PH_PLAIN;
                  count_in = 2'd0;
                  has0 = 1'b1;
                  b0   = grown[7:0];
               end
            end else begin
               count_in = 2'd0;
               has0 = 1'b1;
               b0   = value_ff[7:0];
               l0   = 1'b0;
               has1 = plain_emits;
               phase_in = plain_emits ? PH_PLAIN : PH_ESC;
            end
         end
         default: begin
            has0 = plain_emits;
            phase_in = plain_emits ? PH_PLAIN : PH_ESC;
         end
      endcase
   end

   assign push_valid      = accept && has0;
   assign push_data.pair  = has1;
   assign push_data.byte0 = b0;
   assign push_data.last0 = l0;
   assign push_data.byte1 = b1;
   assign push_data.last1 = l1;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff  <= 1'b0;
         phase_ff <= PH_PLAIN;
         count_ff <= 2'd0;
         value_ff <= 10'd0;
      end else begin
         skip_ff <= skip_in;
         if (accept) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            value_ff <= value_in;
         end
      end
   end

endmodule

// ===== rtl/core/esd_queue.sv =====
// ----------------------------------------------------------------------------
// esd_queue
// Short result queue between the classifying front and the output back end.
// ----------------------------------------------------------------------------
module esd_queue #(
   parameter int unsigned DEPTH = esd_pkg::QueueDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  esd_pkg::result_type  push_data,
   output logic                 push_ready,
   output logic                 head_valid,
   output esd_pkg::result_type  head_data,
   input  logic                 pop
);

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

   esd_pkg::result_type entry_mem_ff [DEPTH];

   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != FullCnt;
   assign head_valid = count_ff != '0;
   assign head_data  = entry_mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/esd_back.sv =====
// ----------------------------------------------------------------------------
// esd_back
// Output stage: sends queued bytes one per cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
module esd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  esd_pkg::result_type  head_data,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast
);

   logic                slot_valid_ff, slot_valid_in;
   logic                sel_ff, sel_in;
   esd_pkg::result_type slot_ff;
   logic                fire, done, free;

   assign rsp_tvalid = slot_valid_ff;
   assign rsp_tdata  = sel_ff ? slot_ff.byte1 : slot_ff.byte0;
   assign rsp_tlast  = sel_ff ? slot_ff.last1 : slot_ff.last0;

   assign fire = slot_valid_ff && rsp_tready;
   assign done = fire && (sel_ff || !slot_ff.pair);
   assign free = !slot_valid_ff || done;
   assign pop  = free && head_valid;

   always_comb begin
      slot_valid_in = slot_valid_ff;
      sel_in        = sel_ff;
      if (pop) begin
         slot_valid_in = 1'b1;
         sel_in        = 1'b0;
      end else if (done) begin
         slot_valid_in = 1'b0;
         sel_in        = 1'b0;
      end else if (fire) begin
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         slot_ff <= head_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         sel_ff        <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         sel_ff        <= sel_in;
      end
   end

endmodule

// ===== rtl/core/escape_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Streaming decoder of C-style backslash escapes, one character per request.
// ----------------------------------------------------------------------------
//   channel  direction  payload
//   req_     in         tdata[7:0] char_in, tlast last_char
//   rsp_     out        tdata[7:0] char_out, tlast last_out
//   csr_     in         data: skip_decimal_escapes
//
// One request is taken per cycle while the result queue has room.
// A request yields zero to two bytes; the output sends one byte per cycle
// while rsp_tready is high, so two-byte requests are limited by the output.
// rsp_tvalid rises once the request has been written into the queue and then
// loaded into the output slot register. Reset is synchronous and empties the
// queue; req_tready drops only when the queue is full.
// ----------------------------------------------------------------------------
module escape_sequence_decoder #(
   parameter int unsigned QUEUE_DEPTH = esd_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] char_out
   output logic       rsp_tlast,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data
);

   logic                push_valid, push_ready;
   esd_pkg::result_type push_data;
   logic                head_valid, pop;
   esd_pkg::result_type head_data;

   esd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   esd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   esd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/core/esd_checker.sv =====
// ----------------------------------------------------------------------------
// esd_checker
// Port-level checks of the escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module esd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result pending after reset");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a matching request");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
